/* hdl/gccc_pkg.sv */
// shared types and constants for the grid cycle cover counter
// no dependencies; imported by gccc_sweep, grid_cycle_cover_counter_unit, gccc_checker and tb_top
package gccc_pkg;

    localparam int APB_AW = 3;

    // register indexes, taken from paddr[2]
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // how the write stage forms the new profile count
    typedef enum logic [1:0] {
        SEL_ZERO = 2'd0,
        SEL_ONE  = 2'd1,
        SEL_A    = 2'd2,
        SEL_SUM  = 2'd3
    } comb_sel_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic overflow;
    } sweep_stat_t;

endpackage

/* hdl/gccc_sweep.sv */
// plug dp sweep: row store, two-bank profile memory, shared 64-bit adder, sequencer
// depends on gccc_pkg
module gccc_sweep #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 12
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       row_we,
    input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] row_waddr,
    input  logic [MAX_COLS-1:0]                        row_wdata,
    input  logic                                       start,
    input  logic [$clog2(MAX_ROWS+1)-1:0]              rows_used,
    input  logic [$clog2(MAX_COLS+1)-1:0]              cols_used,
    input  logic                                       ack,
    output gccc_pkg::sweep_stat_t                      stat,
    output logic [63:0]                                count
);
    import gccc_pkg::*;

    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SW  = MAX_COLS + 1;
    localparam int AW  = SW + 1;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_FETCH_A = 7'b0000010,
        S_FETCH_B = 7'b0000100,
        S_FETCH_C = 7'b0001000,
        S_STEP    = 7'b0010000,
        S_DRAIN   = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [RIW-1:0]      r_reg, r_next;
    logic [CIW-1:0]      c_reg, c_next;
    logic                shift_reg, shift_next;
    logic                bank_reg, bank_next;
    logic [SW-1:0]       t_reg, t_next;
    logic [MAX_COLS-1:0] cur_row_reg, cur_row_next;
    logic [MAX_COLS-1:0] nxt_row_reg, nxt_row_next;
    logic                wr_valid_reg;
    logic [SW-1:0]       wr_t_reg;
    comb_sel_t           wr_sel_reg;
    logic [63:0]         cnt_reg;
    logic                ovf_reg;

    logic [MAX_COLS-1:0] row_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] row_rd_reg;
    logic [RIW-1:0]      row_raddr;

    logic [63:0]         prof_mem [DEPTH];
    logic [63:0]         rd_a_reg, rd_b_reg;
    logic [AW-1:0]       ra, rb, wa;
    logic [63:0]         wd;
    logic [64:0]         sum;
    logic                we;

    logic [SW-1:0]       t_last, lb, ub, a_state, b_state;
    logic [MAX_COLS:0]   row_ext;
    logic                bit_l, bit_u, here, down, right;
    logic                last_row, last_col, last_step, next_row_in;
    comb_sel_t           sel;

    assign t_last      = SW'((32'd1 << (int'(cols_used) + 1)) - 32'd1);
    assign last_row    = int'(r_reg) == int'(rows_used) - 1;
    assign last_col    = int'(c_reg) == int'(cols_used) - 1;
    assign last_step   = !shift_reg && last_row && last_col;
    assign next_row_in = int'(r_reg) + 1 < int'(rows_used);

    // plug bits either side of the current cell
    assign lb      = SW'(1) << c_reg;
    assign ub      = lb << 1;
    assign bit_l   = |(t_reg & lb);
    assign bit_u   = |(t_reg & ub);
    assign row_ext = {1'b0, cur_row_reg} >> c_reg;
    assign here    = row_ext[0];
    assign right   = row_ext[1];
    assign down    = nxt_row_reg[c_reg];

    // gather form: each target profile pulls from at most two source profiles
    always_comb
    begin
        a_state = t_reg;
        b_state = t_reg ^ lb ^ ub;
        sel     = SEL_ZERO;
        if (shift_reg)
        begin
            a_state = t_reg >> 1;
            if (r_reg == '0)
                sel = (t_reg == '0) ? SEL_ONE : SEL_ZERO;
            else
                sel = t_reg[0] ? SEL_ZERO : SEL_A;
        end
        else if (!here)
        begin
            sel = (!bit_l && !bit_u) ? SEL_A : SEL_ZERO;
        end
        else
        begin
            case ({bit_l, bit_u})
                2'b00:
                begin
                    a_state = t_reg | lb | ub;
                    sel     = SEL_A;
                end
                2'b10:   sel = down ? SEL_SUM : SEL_ZERO;
                2'b01:   sel = right ? SEL_SUM : SEL_ZERO;
                2'b11:
                begin
                    a_state = t_reg & ~(lb | ub);
                    sel     = (down && right) ? SEL_A : SEL_ZERO;
                end
                default: sel = SEL_ZERO;
            endcase
        end
    end

    assign ra  = {bank_reg, a_state};
    assign rb  = {bank_reg, b_state};
    assign wa  = {~bank_reg, wr_t_reg};
    assign we  = wr_valid_reg;
    assign sum = {1'b0, rd_a_reg} + {1'b0, rd_b_reg};

    always_comb
    begin
        case (wr_sel_reg)
            SEL_ZERO: wd = '0;
            SEL_ONE:  wd = 64'd1;
            SEL_A:    wd = rd_a_reg;
            SEL_SUM:  wd = sum[63:0];
            default:  wd = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            prof_mem[wa] <= wd;
        rd_a_reg <= prof_mem[ra];
        rd_b_reg <= prof_mem[rb];
    end

    assign row_raddr = (state_reg == S_FETCH_B) ? RIW'(r_reg + 1'b1) : r_reg;

    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[row_waddr] <= row_wdata;
        row_rd_reg <= row_mem[row_raddr];
    end

    always_comb
    begin
        state_next   = state_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        shift_next   = shift_reg;
        bank_next    = bank_reg;
        t_next       = t_reg;
        cur_row_next = cur_row_reg;
        nxt_row_next = nxt_row_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    r_next     = '0;
                    state_next = S_FETCH_A;
                end
            end
            S_FETCH_A: state_next = S_FETCH_B;
            S_FETCH_B:
            begin
                cur_row_next = row_rd_reg;
                state_next   = S_FETCH_C;
            end
            S_FETCH_C:
            begin
                nxt_row_next = next_row_in ? row_rd_reg : '0;
                shift_next   = 1'b1;
                t_next       = '0;
                state_next   = S_STEP;
            end
            S_STEP:
            begin
                t_next = t_reg + 1'b1;
                if (t_reg == t_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                bank_next = ~bank_reg;
                t_next    = '0;
                if (shift_reg)
                begin
                    shift_next = 1'b0;
                    c_next     = '0;
                    state_next = S_STEP;
                end
                else if (!last_col)
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_STEP;
                end
                else if (!last_row)
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = S_FETCH_A;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (ack)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            r_reg        <= '0;
            c_reg        <= '0;
            shift_reg    <= 1'b0;
            bank_reg     <= 1'b0;
            t_reg        <= '0;
            wr_valid_reg <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            shift_reg    <= shift_next;
            bank_reg     <= bank_next;
            t_reg        <= t_next;
            wr_valid_reg <= (state_reg == S_STEP);
            if (state_reg == S_IDLE && start)
                ovf_reg <= 1'b0;
            else if (we && wr_sel_reg == SEL_SUM && sum[64])
                ovf_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_row_reg <= cur_row_next;
        nxt_row_reg <= nxt_row_next;
        wr_t_reg    <= t_reg;
        wr_sel_reg  <= sel;
        // the empty profile after the last cell is the answer
        if (we && last_step && wr_t_reg == '0)
            cnt_reg <= wd;
    end

    assign stat.busy     = (state_reg != S_IDLE);
    assign stat.done     = (state_reg == S_DONE);
    assign stat.overflow = ovf_reg;
    assign count         = cnt_reg;

endmodule

/* hdl/grid_cycle_cover_counter_unit.sv */
// grid cycle cover counter top level: apb registers, cell loading, result register
// depends on gccc_pkg and gccc_sweep
//
//  channel  | signals                       | payload
//  ---------+-------------------------------+------------------------------
//  in       | in_valid, in_stall            | cell_open
//  out      | out_valid, out_stall          | way_count, count_overflow
//  config   | psel penable pwrite paddr ... | grid_rows (0x0), grid_cols (0x4)
//
// cells load at one per cycle while in_stall is low, in row-major order; the last cell starts the sweep
// the sweep steps through one profile per cycle
// through the profile memory and its single shared 64-bit adder
// in_stall is high for the whole sweep; the result waits in its register under out_stall
// rst_n clears control state asynchronously; the profile memory needs no clearing
module grid_cycle_cover_counter_unit #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gccc_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cell_open,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [63:0]                   way_count,
    output logic                          count_overflow
);
    import gccc_pkg::*;

    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);

    logic [4:0]          grid_rows_reg;
    logic [3:0]          grid_cols_reg;
    logic [RIW-1:0]      row_cnt_reg;
    logic [CIW-1:0]      col_cnt_reg;
    logic [MAX_COLS-1:0] row_buf_reg;
    logic [MAX_COLS-1:0] row_buf_next;
    logic                out_valid_reg;
    logic [63:0]         way_count_reg;
    logic                count_overflow_reg;

    logic [RCW-1:0]      rows_used;
    logic [CCW-1:0]      cols_used;
    logic                cfg_wr, accept, row_done, grid_done, ack;
    sweep_stat_t         stat;
    logic [63:0]         count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_ROWS: prdata = 32'(grid_rows_reg);
            REG_COLS: prdata = 32'(grid_cols_reg);
            default:  prdata = '0;
        endcase
    end

    // out-of-range sizes saturate into the supported grid
    assign rows_used = (grid_rows_reg == '0) ? RCW'(1) :
                       (int'(grid_rows_reg) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(grid_rows_reg);
    assign cols_used = (grid_cols_reg == '0) ? CCW'(1) :
                       (int'(grid_cols_reg) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(grid_cols_reg);

    assign in_stall     = stat.busy;
    assign accept       = in_valid && !in_stall;
    assign row_done     = accept && (int'(col_cnt_reg) == int'(cols_used) - 1);
    assign grid_done    = row_done && (int'(row_cnt_reg) == int'(rows_used) - 1);
    assign row_buf_next = row_buf_reg | (MAX_COLS'(cell_open) << col_cnt_reg);
    assign ack          = stat.done && (!out_valid_reg || !out_stall);

    gccc_sweep #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_sweep (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_we    (row_done),
        .row_waddr (row_cnt_reg),
        .row_wdata (row_buf_next),
        .start     (grid_done),
        .rows_used (rows_used),
        .cols_used (cols_used),
        .ack       (ack),
        .stat      (stat),
        .count     (count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= 5'd1;
            grid_cols_reg <= 4'd1;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            row_buf_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                // any register write restarts the load
                if (paddr[2] == REG_ROWS)
                    grid_rows_reg <= pwdata[4:0];
                else
                    grid_cols_reg <= pwdata[3:0];
                row_cnt_reg <= '0;
                col_cnt_reg <= '0;
                row_buf_reg <= '0;
            end
            else if (accept)
            begin
                if (row_done)
                begin
                    col_cnt_reg <= '0;
                    row_buf_reg <= '0;
                    row_cnt_reg <= grid_done ? '0 : RIW'(row_cnt_reg + 1'b1);
                end
                else
                begin
                    col_cnt_reg <= CIW'(col_cnt_reg + 1'b1);
                    row_buf_reg <= row_buf_next;
                end
            end
            if (ack)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ack)
        begin
            way_count_reg      <= count;
            count_overflow_reg <= stat.overflow;
        end
    end

    assign out_valid      = out_valid_reg;
    assign way_count      = way_count_reg;
    assign count_overflow = count_overflow_reg;

    a_ack_free : assert property (@(posedge clk) disable iff (!rst_n)
        ack |-> (!out_valid_reg || !out_stall))
        else $error("sweep result taken over a stalled request");

    a_out_from_ack : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ack))
        else $error("result appeared without a finished sweep");

    a_start_idle : assert property (@(posedge clk) disable iff (!rst_n)
        grid_done |-> !stat.busy)
        else $error("sweep started while busy");

endmodule

/* test/gccc_checker.sv */
`timescale 1ns / 1ps
// grid cycle cover checker: watches the apb, cell and result channels,
// predicts each loop-cover count and compares it; depends on gccc_pkg
module gccc_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gccc_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        cell_open,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [63:0]                 way_count,
    input  logic                        count_overflow,
    output int                          fails,
    output int                          pending
);
    import gccc_pkg::*;

    localparam int GRID_ROWS_MAX = 16;
    localparam int GRID_COLS_MAX = 12;
    localparam int PROFILES = 1 << (GRID_COLS_MAX + 1);

    typedef struct {
        logic [63:0] ways;
        logic        wrapped;
    } cover_result_t;

    logic [4:0]    rows_reg;
    logic [3:0]    cols_reg;
    bit            cell_map [0:GRID_ROWS_MAX*GRID_COLS_MAX-1];
    int            loaded;
    logic [63:0]   prof [0:1][0:PROFILES-1];
    bit            sweep_wrapped;
    cover_result_t covers_due [$];

    function int rows_in_use();
        if (rows_reg < 1) return 1;
        if (rows_reg > GRID_ROWS_MAX) return GRID_ROWS_MAX;
        return rows_reg;
    endfunction

    function int cols_in_use();
        if (cols_reg < 1) return 1;
        if (cols_reg > GRID_COLS_MAX) return GRID_COLS_MAX;
        return cols_reg;
    endfunction

    function bit cell_is_open(int r, int c, int rows, int cols);
        if (r >= rows || c >= cols) return 0;
        return cell_map[r*GRID_COLS_MAX + c];
    endfunction

    function void add_profile(int bank, int s, logic [63:0] v);
        logic [64:0] sum;
        sum = {1'b0, prof[bank][s]} + {1'b0, v};
        if (sum[64])
            sweep_wrapped = 1;
        prof[bank][s] = sum[63:0];
    endfunction

    function void clear_bank(int bank, int nst);
        for (int s = 0; s < nst; s++)
            prof[bank][s] = '0;
    endfunction

    // broken-profile sweep: bit c is the plug on the left of column c, bit c+1 above it
    function logic [63:0] count_covers();
        int rows, cols, nst, topbit, cur, nxt, lb, ub;
        bit here, down, right, lf, uf;
        logic [63:0] v;
        rows = rows_in_use();
        cols = cols_in_use();
        nst = 1 << (cols + 1);
        topbit = 1 << cols;
        cur = 0;
        sweep_wrapped = 0;
        clear_bank(0, nst);
        prof[0][0] = 64'd1;
        for (int r = 0; r < rows; r++) begin
            nxt = cur ^ 1;
            clear_bank(nxt, nst);
            for (int s = 0; s < nst; s++)
                if ((s & topbit) == 0)
                    prof[nxt][(s << 1) & (PROFILES - 1)] = prof[cur][s];
            cur = nxt;
            for (int c = 0; c < cols; c++) begin
                lb = 1 << c;
                ub = 1 << (c + 1);
                here = cell_is_open(r, c, rows, cols);
                down = cell_is_open(r + 1, c, rows, cols);
                right = cell_is_open(r, c + 1, rows, cols);
                nxt = cur ^ 1;
                clear_bank(nxt, nst);
                for (int s = 0; s < nst; s++) begin
                    v = prof[cur][s];
                    lf = (s & lb) != 0;
                    uf = (s & ub) != 0;
                    if (v != 0) begin
                        if (!here) begin
                            if (!lf && !uf)
                                add_profile(nxt, s, v);
                        end else if (lf && uf) begin
                            add_profile(nxt, s & ~(lb | ub), v);
                        end else if (lf || uf) begin
                            if (down)
                                add_profile(nxt, (s & ~ub) | lb, v);
                            if (right)
                                add_profile(nxt, (s & ~lb) | ub, v);
                        end else if (down && right) begin
                            add_profile(nxt, s | lb | ub, v);
                        end
                    end
                end
                cur = nxt;
            end
        end
        return prof[cur][0];
    endfunction

    function void report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        if (fails < 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        fails++;
    endfunction

    assign pending = covers_due.size();

    always @(posedge clk or negedge rst_n) begin
        int rows, cols, r, c;
        cover_result_t due;
        if (!rst_n) begin
            rows_reg = 5'd1;
            cols_reg = 4'd1;
            loaded = 0;
            fails = 0;
            covers_due.delete();
            for (int i = 0; i < GRID_ROWS_MAX*GRID_COLS_MAX; i++)
                cell_map[i] = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_ROWS)
                    rows_reg = pwdata[4:0];
                else
                    cols_reg = pwdata[3:0];
                loaded = 0;
            end
            if (in_valid && !in_stall) begin
                rows = rows_in_use();
                cols = cols_in_use();
                if (loaded >= rows*cols)
                    loaded = 0;
                r = loaded / cols;
                c = loaded % cols;
                cell_map[r*GRID_COLS_MAX + c] = cell_open;
                loaded++;
                if (loaded == rows*cols) begin
                    due.ways = count_covers();
                    due.wrapped = sweep_wrapped;
                    covers_due.push_back(due);
                    loaded = 0;
                end
            end
            if (out_valid && !out_stall) begin
                if (covers_due.size() == 0) begin
                    if (fails < 10)
                        $display("result with no request waiting: %0d", way_count);
                    fails++;
                end else begin
                    due = covers_due.pop_front();
                    if (way_count !== due.ways)
                        report_mismatch("way_count", due.ways, way_count);
                    if (count_overflow !== due.wrapped)
                        report_mismatch("count_overflow", due.wrapped, count_overflow);
                end
            end
        end
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// testbench top for grid_cycle_cover_counter_unit: clock, reset, apb writes,
// cell requests and result stalls; checking is done in gccc_checker
module tb_top;
    import gccc_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                psel, penable, pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid, in_stall, cell_open;
    logic                out_valid, out_stall;
    logic [63:0]         way_count;
    logic                count_overflow;
    logic                cell_taken;
    int                  fails, pending;
    int                  cells_sent;
    int                  stall_left;

    grid_cycle_cover_counter_unit dut (.*);

    gccc_checker u_checker (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .in_valid, .in_stall, .cell_open, .out_valid, .out_stall,
        .way_count, .count_overflow, .fails, .pending
    );

    always
    begin
        clk = 0;
        #6;
        clk = 1;
        #6;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_taken <= 0;
        else
            cell_taken <= in_valid && !in_stall;
    end

    // result stalls: mostly short bursts, now and then a long one or a long quiet stretch
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stall_left <= 0;
            out_stall <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            out_stall <= !out_stall && ($urandom_range(0, 2) != 0);
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                       : $urandom_range(0, 3);
        end
    end

    task automatic wait_idle();
        in_valid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1;
        do @(negedge clk); while (!pready);
        psel <= 0;
        penable <= 0;
        @(negedge clk);
    endtask

    task automatic set_grid(int rows, int cols);
        wait_idle();
        write_reg(REG_ROWS, rows);
        write_reg(REG_COLS, cols);
    endtask

    task automatic send_cell(bit v);
        int pick, gap;
        pick = $urandom_range(0, 9);
        gap = (pick < 6) ? 0 : (pick < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        cell_open <= v;
        do @(negedge clk); while (!cell_taken);
        cells_sent++;
    endtask

    task automatic send_grid(int ncells, int open_pct);
        for (int i = 0; i < ncells; i++)
            send_cell($urandom_range(0, 99) < open_pct);
    endtask

    initial
    begin
        #40_000_000;
        $display("grid_cycle_cover_counter_unit verification failed");
        $finish;
    end

    initial
    begin
        int rows, cols, sel;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        in_valid = 0;
        cell_open = 0;
        cells_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // reset shape is one cell: blocked and open
        send_cell(0);
        send_cell(1);
        // 2x2 ring, then a restart of the load part-way through
        set_grid(2, 2);
        send_grid(4, 100);
        wait_idle();
        send_cell(1);
        send_cell(0);
        in_valid <= 0;
        wait_idle();
        write_reg(REG_COLS, 2);
        send_grid(4, 100);
        // zero registers saturate up to one
        set_grid(0, 0);
        send_cell(1);
        // all-ones registers saturate to the largest grid shapes
        set_grid(31, 1);
        send_grid(16, 0);
        set_grid(1, 15);
        send_grid(12, 100);

        while (cells_sent < 1000) begin
            sel = $urandom_range(0, 19);
            rows = $urandom_range(1, 6);
            cols = $urandom_range(1, 5);
            if (sel == 0)
                rows = $urandom_range(7, 16);
            else if (sel == 1)
                cols = $urandom_range(6, 8);
            else if (sel == 2)
                rows = $urandom_range(17, 31);
            else if (sel == 3)
                rows = 0;
            set_grid(rows, cols);
            sel = $urandom_range(0, 9);
            rows = (rows < 1) ? 1 : (rows > 16) ? 16 : rows;
            if (sel == 0) begin
                // broken load, restarted by a register write
                send_grid($urandom_range(1, rows*cols), 50);
                in_valid <= 0;
                wait_idle();
                write_reg(REG_ROWS, rows);
            end
            send_grid(rows*cols, (sel < 4) ? 100 : (sel < 8) ? 85 : 50);
            in_valid <= 0;
        end

        in_valid <= 0;
        wait_idle();
        if (fails == 0)
            $display("grid_cycle_cover_counter_unit verification clean");
        else
            $display("grid_cycle_cover_counter_unit verification failed");
        $finish;
    end

endmodule
